### hw/rtl/ppfm_pkg.sv
// Shared types and constants for the pulse period frequency meter.
`timescale 1ns / 1ps

package ppfm_pkg;

  localparam int unsigned TpsWidth        = 24;
  localparam logic [TpsWidth-1:0] TpsReset = 24'd200000;
  localparam int unsigned RunWidthDefault = 16;

  typedef struct packed {
    logic func;
    logic level;
  } in_t;

  typedef struct packed {
    logic [TpsWidth-1:0] frequency;
    logic                zero_period;
  } out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

### hw/rtl/pulse_period_frequency_meter_unit.sv
// Top level of the pulse period frequency meter: run counters, capture, report.
//
//   channel | direction | word
//   in      | input     | ppfm_pkg::in_t  (func, level)
//   out     | output    | ppfm_pkg::out_t (frequency, zero_period)
//   cfg     | input     | ticks_per_second, 24 bits
//
// A sample word updates the run counters as it is accepted. A report word runs the bit-serial divider,
// one quotient bit per cycle, and the result word is then loaded into the output register.
// Input is held off while the divider runs or holds a result for a full output.
// Reset clears run counters, captures and phase; ticks_per_second resets to 200000.
// Config writes are always taken.
`timescale 1ns / 1ps

module pulse_period_frequency_meter_unit #(
  parameter int unsigned RUN_WIDTH = ppfm_pkg::RunWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  ppfm_pkg::in_t                 in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output ppfm_pkg::out_t                out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppfm_pkg::TpsWidth-1:0] cfg_data_i
);

  localparam int unsigned PerWidth = RUN_WIDTH + 1;

  logic [ppfm_pkg::TpsWidth-1:0] tps_q;
  logic [RUN_WIDTH-1:0]          high_run_q, low_run_q;
  logic [RUN_WIDTH-1:0]          cap_high_q, cap_low_q;
  logic                          in_low_phase_q;
  logic [PerWidth-1:0]           period;
  logic                          zero_q;
  logic                          in_fire, sample_fire, report_fire;
  logic                          load_out;
  logic                          out_valid_q;
  ppfm_pkg::out_t                out_data_q;
  ppfm_pkg::div_status_t         div_st;
  logic [ppfm_pkg::TpsWidth-1:0] quotient;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !div_st.busy && !div_st.done;
  assign in_fire     = in_valid_i && in_ready_o;
  assign sample_fire = in_fire && !in_data_i.func;
  assign report_fire = in_fire && in_data_i.func;
  assign load_out    = div_st.done && (!out_valid_q || out_ready_i);
  assign period      = {1'b0, cap_high_q} + {1'b0, cap_low_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= ppfm_pkg::TpsReset;
    end else if (cfg_valid_i) begin
      tps_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      high_run_q     <= '0;
      low_run_q      <= '0;
      cap_high_q     <= '0;
      cap_low_q      <= '0;
      in_low_phase_q <= 1'b0;
    end else if (sample_fire) begin
      if (!in_data_i.level) begin
        low_run_q <= (low_run_q == '1) ? low_run_q : low_run_q + 1'b1;
        if (!in_low_phase_q) begin
          in_low_phase_q <= 1'b1;
          cap_high_q     <= high_run_q;
          high_run_q     <= '0;
        end
      end else begin
        high_run_q <= (high_run_q == '1) ? high_run_q : high_run_q + 1'b1;
        if (in_low_phase_q) begin
          in_low_phase_q <= 1'b0;
          cap_low_q      <= low_run_q;
          low_run_q      <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (report_fire) begin
      zero_q <= (period == '0);
    end
  end

  ppfm_div #(
    .DVS_WIDTH(PerWidth)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (report_fire),
    .ack_i      (load_out),
    .dividend_i (tps_q),
    .divisor_i  (period),
    .status_o   (div_st),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_data_q.frequency   <= zero_q ? '0 : quotient;
      out_data_q.zero_period <= zero_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_report_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    report_fire |=> div_st.busy)
    else $error("report word did not start the divider");

  a_done_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |=> out_valid_o)
    else $error("finished division did not reach the output");

  a_zero_flag_freq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.zero_period |-> out_data_o.frequency == '0)
    else $error("zero period with nonzero frequency");

  a_low_sample_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_fire && !in_data_i.level |=> in_low_phase_q && low_run_q != '0)
    else $error("low sample did not enter low phase");
`endif

endmodule

### hw/rtl/ppfm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module ppfm_div #(
  parameter int unsigned DVS_WIDTH = ppfm_pkg::RunWidthDefault + 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           ack_i,
  input  logic [ppfm_pkg::TpsWidth-1:0]  dividend_i,
  input  logic [DVS_WIDTH-1:0]           divisor_i,
  output ppfm_pkg::div_status_t          status_o,
  output logic [ppfm_pkg::TpsWidth-1:0]  quotient_o
);

  localparam int unsigned QW       = ppfm_pkg::TpsWidth;
  localparam int unsigned CntWidth = $clog2(QW);

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDone
  } state_e;

  state_e                state_q, state_d;
  logic [CntWidth-1:0]   cnt_q, cnt_d;
  logic [DVS_WIDTH-1:0]  rem_q, rem_d;
  logic [DVS_WIDTH-1:0]  dvs_q, dvs_d;
  logic [QW-1:0]         dq_q, dq_d;
  logic [DVS_WIDTH:0]    shifted;
  logic [DVS_WIDTH:0]    diff;
  logic                  ge;

  assign shifted = {rem_q, dq_q[QW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    dq_d    = dq_q;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StRun;
          cnt_d   = CntWidth'(QW - 1);
          rem_d   = '0;
          dvs_d   = divisor_i;
          dq_d    = dividend_i;
        end
      end
      StRun: begin
        rem_d = ge ? diff[DVS_WIDTH-1:0] : shifted[DVS_WIDTH-1:0];
        dq_d  = {dq_q[QW-2:0], ge};
        if (cnt_q == '0) begin
          state_d = StDone;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      StDone: begin
        if (ack_i) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    dq_q  <= dq_d;
  end

  assign status_o.busy = (state_q == StRun);
  assign status_o.done = (state_q == StDone);
  assign quotient_o    = dq_q;

endmodule

### test/ppfm_reading_checker.sv
// Predicts frequency readings from accepted words and checks the output channel against them.
`timescale 1ns / 1ps

module ppfm_reading_checker #(
  parameter int unsigned RUN_WIDTH = ppfm_pkg::RunWidthDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  ppfm_pkg::in_t                 in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  ppfm_pkg::out_t                out_data_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [ppfm_pkg::TpsWidth-1:0] cfg_data_i,
  output int unsigned                   pending_o,
  output int unsigned                   errors_o
);

  localparam logic [RUN_WIDTH-1:0] RunMax = '1;

  logic [ppfm_pkg::TpsWidth-1:0] tps;
  logic [RUN_WIDTH-1:0]          high_len;
  logic [RUN_WIDTH-1:0]          low_len;
  logic [RUN_WIDTH-1:0]          last_high;
  logic [RUN_WIDTH-1:0]          last_low;
  logic                          low_phase;
  ppfm_pkg::out_t                readings_q[$];
  int unsigned                   errors;

  function automatic ppfm_pkg::out_t predict_reading();
    logic [RUN_WIDTH:0] period;
    ppfm_pkg::out_t     r;
    period = {1'b0, last_high} + {1'b0, last_low};
    if (period == '0) begin
      r.frequency   = '0;
      r.zero_period = 1'b1;
    end else begin
      r.frequency   = tps / period;
      r.zero_period = 1'b0;
    end
    return r;
  endfunction

  task automatic take_sample(input logic level);
    if (!level) begin
      if (low_len != RunMax) low_len++;
      if (!low_phase) begin
        low_phase = 1'b1;
        last_high = high_len;
        high_len  = '0;
      end
    end else begin
      if (high_len != RunMax) high_len++;
      if (low_phase) begin
        low_phase = 1'b0;
        last_low  = low_len;
        low_len   = '0;
      end
    end
  endtask

  task automatic note_error(input string what, input int unsigned exp_v, input int unsigned act_v);
    errors++;
    if (errors <= 10) begin
      $display("ERROR at %0t: %s expected %0d, got %0d", $time, what, exp_v, act_v);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ppfm_pkg::out_t exp_r;
    if (!rst_ni) begin
      tps       = ppfm_pkg::TpsReset;
      high_len  = '0;
      low_len   = '0;
      last_high = '0;
      last_low  = '0;
      low_phase = 1'b0;
      errors    = 0;
      readings_q.delete();
      pending_o <= 0;
      errors_o  <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        tps = cfg_data_i;
      end
      if (out_valid_i && out_ready_i) begin
        if (readings_q.size() == 0) begin
          note_error("word with no reading due, frequency", 0, 32'(out_data_i.frequency));
        end else begin
          exp_r = readings_q.pop_front();
          if (out_data_i.frequency !== exp_r.frequency) begin
            note_error("frequency", 32'(exp_r.frequency), 32'(out_data_i.frequency));
          end
          if (out_data_i.zero_period !== exp_r.zero_period) begin
            note_error("zero_period", 32'(exp_r.zero_period), 32'(out_data_i.zero_period));
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_data_i.func) begin
          readings_q.push_back(predict_reading());
        end else begin
          take_sample(in_data_i.level);
        end
      end
      pending_o <= unsigned'(readings_q.size());
      errors_o  <= errors;
    end
  end

endmodule

### test/pulse_period_frequency_meter_unit_tb.sv
// Stimulus and verdict for the pulse period frequency meter: samples, reports, rate writes.
`timescale 1ns / 1ps

module pulse_period_frequency_meter_unit_tb;

  localparam int unsigned TpsW         = ppfm_pkg::TpsWidth;
  localparam logic        FuncSample   = 1'b0;
  localparam logic        FuncReport   = 1'b1;
  localparam logic        LevelLow     = 1'b0;
  localparam logic        LevelHigh    = 1'b1;
  localparam int unsigned StallLimit   = 5000;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned RandomWords  = 500;
  localparam int unsigned Phases       = 5;
  localparam int unsigned LongRun      = 150;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  ppfm_pkg::in_t       in_data = '0;
  logic                in_ready;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ppfm_pkg::out_t      out_data;
  logic                cfg_valid = 1'b0;
  logic [TpsW-1:0]     cfg_data = '0;
  logic                cfg_ready;
  int unsigned         pending;
  int unsigned         errors;
  int unsigned         burst_left = 0;
  int unsigned         words_sent = 0;
  int unsigned         idle_cycles = 0;
  int unsigned         rx_cyc = 0;

  pulse_period_frequency_meter_unit i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  ppfm_reading_checker i_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_i (in_ready),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_ready_i(out_ready),
    .out_data_i (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_i(cfg_ready),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .errors_o   (errors)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(negedge clk) begin
    rx_cyc    <= rx_cyc + 1;
    out_ready <= (rx_cyc[8:7] == 2'b11) ||
                 ((rx_cyc[10:9] == 2'b01) ? ($urandom_range(0, 2) == 0) :
                                            (rx_cyc % 5 != 2 && rx_cyc % 13 >= 3));
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("pulse_period_frequency_meter_unit: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_word(input logic func, input logic level);
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 24);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= ppfm_pkg::in_t'{func: func, level: level};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    words_sent++;
  endtask

  task automatic send_run(input logic level, input int unsigned len);
    repeat (len) send_word(FuncSample, level);
  endtask

  task automatic request_report();
    send_word(FuncReport, 1'($urandom_range(0, 1)));
  endtask

  // hold input until every reading is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_tps(input logic [TpsW-1:0] value);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [TpsW-1:0] tps_value;
    logic            lvl;
    int unsigned     len;
    int unsigned     target;
    bit              paused;

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    send_word(FuncReport, LevelHigh);
    send_word(FuncReport, LevelLow);
    send_run(LevelHigh, 2);
    send_run(LevelLow, 3);
    request_report();
    send_word(FuncSample, LevelHigh);
    request_report();
    send_word(FuncSample, LevelLow);
    send_word(FuncSample, LevelHigh);
    send_word(FuncSample, LevelLow);
    send_word(FuncSample, LevelHigh);
    request_report();
    write_tps('0);
    request_report();
    write_tps(TpsW'(1));
    request_report();
    write_tps('1);
    request_report();

    // hold long runs on both levels before a report
    send_run(LevelHigh, LongRun);
    send_run(LevelLow, LongRun);
    send_word(FuncSample, LevelHigh);
    request_report();
    request_report();

    for (int p = 0; p < Phases; p++) begin
      unique case (p)
        0:       tps_value = TpsW'($urandom_range(1, 24'hFFFFFF));
        1:       tps_value = TpsW'($urandom_range(1, 1000));
        2:       tps_value = TpsW'(1);
        3:       tps_value = '1;
        default: tps_value = ppfm_pkg::TpsReset;
      endcase
      write_tps(tps_value);
      target = words_sent + RandomWords / Phases;
      paused = 1'b0;
      while (words_sent < target) begin
        if (!paused && words_sent + RandomWords / (2 * Phases) >= target) begin
          drain();
          paused = 1'b1;
        end
        if ($urandom_range(0, 4) != 0) begin
          lvl = 1'($urandom_range(0, 1));
          len = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 12);
          send_run(lvl, len);
          if ($urandom_range(0, 2) != 0) request_report();
        end else begin
          send_word(($urandom_range(0, 2) == 0) ? FuncReport : FuncSample,
                    1'($urandom_range(0, 1)));
        end
      end
    end

    drain();
    if (errors == 0) begin
      $display("pulse_period_frequency_meter_unit: match");
    end else begin
      $display("pulse_period_frequency_meter_unit: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/ppfm_pkg.sv
hw/rtl/ppfm_div.sv
hw/rtl/pulse_period_frequency_meter_unit.sv
test/ppfm_reading_checker.sv
test/pulse_period_frequency_meter_unit_tb.sv
